/* src/gptc_pkg.sv */
package gptc_pkg;

	// Default largest image side; the bitmap holds MAX_SIDE x MAX_SIDE cells.
	localparam int MAX_SIDE_DEF = 32;

	// Widths fixed by the register map and the result word.
	localparam int CFG_W = 6;
	localparam int LEN_W = 11;

	// Value of both dimension registers after reset.
	localparam logic [CFG_W-1:0] DIM_RESET = 6'd5;

	// Register indexes on the configuration port.
	localparam logic CFG_ROWS = 1'b0;
	localparam logic CFG_COLS = 1'b1;

	// Neighbor probe order; the walk prefers the first open neighbor in this order.
	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_LEFT  = 2'd1;
	localparam logic [1:0] DIR_DOWN  = 2'd2;
	localparam logic [1:0] DIR_RIGHT = 2'd3;

endpackage

/* src/gptc_ram.sv */
module gptc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

/* src/grid_path_trace_check_core.sv */
// Path trace checker. Pixels arrive one word per cycle in raster order on start; a word is taken
// at every clock edge where start is high and busy is low, so an image streams in at one pixel
// per cycle. The word with last_pixel set starts a trace of the branch-free conductive path from
// the top-left corner; busy stays high until the verdict is out. The trace shares one read port
// of the bitmap memory and one coordinate increment-or-decrement unit between all four neighbor
// probes: the start cell is read, then checked; each step of the walk probes the neighbors in
// order (an out-of-range one skips the memory read, an in-range one is read from the memory),
// then decides and checks; at most two neighbors of a cell are out of range. The verdict word
// (path_good, path_length) is shown for exactly one cycle with done high, in the same cycle
// that busy falls; it cannot be held off, so the receiver must take it then. A new pixel may be
// offered in that same cycle. The image dimensions are written through cfg_we, cfg_index and
// cfg_wdata while the block is idle, a rule on the user that the block does not enforce; values
// below 2 act as 2 and values above MAX_SIDE act as MAX_SIDE. There is no memory clear after
// reset: every cell that a trace reads must have been loaded first.
module grid_path_trace_check_core #(
	parameter int MAX_SIDE = gptc_pkg::MAX_SIDE_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       pixel_bit,
	input  logic                       last_pixel,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [gptc_pkg::CFG_W-1:0] cfg_wdata,
	output logic                       done,
	output logic                       path_good,
	output logic [gptc_pkg::LEN_W-1:0] path_length
);

	localparam int CFG_W   = gptc_pkg::CFG_W;
	localparam int LEN_W   = gptc_pkg::LEN_W;
	localparam int CFG_MAX = (1 << CFG_W) - 1;
	// Coordinate width and the largest dimension the registers can actually select.
	localparam int CW      = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int DIM_MAX = (MAX_SIDE < CFG_MAX) ? MAX_SIDE : CFG_MAX;
	localparam int DW      = $clog2(DIM_MAX + 1);
	localparam int XW      = CW + 1;
	localparam int SW      = $clog2(DIM_MAX * DIM_MAX + 1);
	localparam int AW      = 2 * CW;
	localparam int DEPTH   = 1 << AW;

	localparam logic [2:0] S_IDLE       = 3'd0;
	localparam logic [2:0] S_ORIGIN     = 3'd1;
	localparam logic [2:0] S_ORIGIN_CHK = 3'd2;
	localparam logic [2:0] S_PROBE      = 3'd3;
	localparam logic [2:0] S_WAIT       = 3'd4;
	localparam logic [2:0] S_DECIDE     = 3'd5;
	localparam logic [2:0] S_CHECK      = 3'd6;

	logic [2:0]       state_q;
	logic [CFG_W-1:0] image_rows_q, image_cols_q;
	logic [DW-1:0]    rows_c, cols_c;
	logic [CW-1:0]    load_row_q, load_col_q;
	logic [CW-1:0]    cur_row_q, cur_col_q, prev_row_q, prev_col_q;
	logic [CW-1:0]    nxt_row_q, nxt_col_q;
	logic [SW-1:0]    step_q, limit_q;
	logic [1:0]       dir_q;
	logic [3:0]       ok_q;
	logic             found_q, first_q;
	logic             done_q, path_good_q;
	logic [LEN_W-1:0] path_length_q;

	logic             accept;
	logic             col_wrap;
	logic [XW-1:0]    load_row_n;
	logic [AW-1:0]    rd_addr;
	logic             rd_data;

	logic             vert, dec;
	logic [CW-1:0]    opnd, nb_sum, nb_row, nb_col;
	logic             nb_inb, nb_back;
	logic [2:0]       open_cnt, need_cnt;
	logic             at_corner;
	logic             fin, fin_good;

	// Registers below 2 or above the largest side are pulled into range.
	always_comb begin
		if (image_rows_q < CFG_W'(2)) begin
			rows_c = DW'(2);
		end else if (image_rows_q > CFG_W'(DIM_MAX)) begin
			rows_c = DW'(DIM_MAX);
		end else begin
			rows_c = DW'(image_rows_q);
		end
		if (image_cols_q < CFG_W'(2)) begin
			cols_c = DW'(2);
		end else if (image_cols_q > CFG_W'(DIM_MAX)) begin
			cols_c = DW'(DIM_MAX);
		end else begin
			cols_c = DW'(image_cols_q);
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// Raster load position: the column wraps at the image width, the row at the image height.
	// The row check runs on every pixel so that a shrunken height also pulls the row back.
	assign col_wrap   = (XW'(load_col_q) + XW'(1)) >= XW'(cols_c);
	assign load_row_n = col_wrap ? XW'(load_row_q) + XW'(1) : XW'(load_row_q);

	// Shared neighbor unit: one increment or decrement of the current row or column,
	// selected by the probe direction.
	assign vert   = (dir_q == gptc_pkg::DIR_UP) || (dir_q == gptc_pkg::DIR_DOWN);
	assign dec    = (dir_q == gptc_pkg::DIR_UP) || (dir_q == gptc_pkg::DIR_LEFT);
	assign opnd   = vert ? cur_row_q : cur_col_q;
	assign nb_sum = dec ? opnd - CW'(1) : opnd + CW'(1);
	assign nb_row = vert ? nb_sum : cur_row_q;
	assign nb_col = vert ? cur_col_q : nb_sum;

	always_comb begin
		unique case (dir_q)
			gptc_pkg::DIR_UP:    nb_inb = (cur_row_q != '0);
			gptc_pkg::DIR_LEFT:  nb_inb = (cur_col_q != '0);
			gptc_pkg::DIR_DOWN:  nb_inb = (XW'(cur_row_q) + XW'(1)) < XW'(rows_c);
			gptc_pkg::DIR_RIGHT: nb_inb = (XW'(cur_col_q) + XW'(1)) < XW'(cols_c);
			default:             nb_inb = 1'b0;
		endcase
	end

	assign nb_back = (nb_row == prev_row_q) && (nb_col == prev_col_q);

	// The start cell needs exactly one open neighbor, every later cell exactly two.
	assign open_cnt  = 3'($countones(ok_q));
	assign need_cnt  = first_q ? 3'd1 : 3'd2;
	assign at_corner = (XW'(cur_row_q) == XW'(rows_c) - XW'(1)) &&
	                   (XW'(cur_col_q) == XW'(cols_c) - XW'(1));

	always_comb begin
		fin      = 1'b0;
		fin_good = 1'b0;
		unique case (state_q)
			S_ORIGIN_CHK: fin = !rd_data;
			S_DECIDE:     fin = (open_cnt != need_cnt);
			S_CHECK: begin
				fin      = at_corner || (step_q >= limit_q);
				fin_good = at_corner;
			end
			default: fin = 1'b0;
		endcase
	end

	// The origin read uses address zero; every other read is the probed neighbor.
	assign rd_addr = (state_q == S_ORIGIN) ? '0 : {nb_row, nb_col};

	gptc_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_bitmap (
		.clk    (clk),
		.we     (accept),
		.wr_addr({load_row_q, load_col_q}),
		.wr_data(pixel_bit),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_rows_q <= gptc_pkg::DIM_RESET;
			image_cols_q <= gptc_pkg::DIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gptc_pkg::CFG_ROWS: image_rows_q <= cfg_wdata;
				gptc_pkg::CFG_COLS: image_cols_q <= cfg_wdata;
				default:            image_rows_q <= image_rows_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			load_row_q <= '0;
			load_col_q <= '0;
			cur_row_q  <= '0;
			cur_col_q  <= '0;
			prev_row_q <= '0;
			prev_col_q <= '0;
			step_q     <= '0;
			limit_q    <= '0;
			dir_q      <= gptc_pkg::DIR_UP;
			ok_q       <= '0;
			found_q    <= 1'b0;
			first_q    <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= fin;
			if (fin) begin
				state_q <= S_IDLE;
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (accept) begin
							if (last_pixel) begin
								load_row_q <= '0;
								load_col_q <= '0;
								cur_row_q  <= '0;
								cur_col_q  <= '0;
								prev_row_q <= '0;
								prev_col_q <= '0;
								step_q     <= '0;
								limit_q    <= SW'(rows_c) * SW'(cols_c);
								state_q    <= S_ORIGIN;
							end else begin
								load_col_q <= col_wrap ? '0 : load_col_q + CW'(1);
								load_row_q <= (load_row_n >= XW'(rows_c)) ? '0 : CW'(load_row_n);
							end
						end
					end
					S_ORIGIN: state_q <= S_ORIGIN_CHK;
					S_ORIGIN_CHK: begin
						dir_q   <= gptc_pkg::DIR_UP;
						ok_q    <= '0;
						found_q <= 1'b0;
						first_q <= 1'b1;
						state_q <= S_PROBE;
					end
					S_PROBE: begin
						if (nb_inb) begin
							state_q <= S_WAIT;
						end else begin
							ok_q[dir_q] <= 1'b0;
							if (dir_q == gptc_pkg::DIR_RIGHT) begin
								state_q <= S_DECIDE;
							end else begin
								dir_q <= dir_q + 2'd1;
							end
						end
					end
					S_WAIT: begin
						ok_q[dir_q] <= rd_data;
						if (rd_data && !nb_back) begin
							found_q <= 1'b1;
						end
						if (dir_q == gptc_pkg::DIR_RIGHT) begin
							state_q <= S_DECIDE;
						end else begin
							dir_q   <= dir_q + 2'd1;
							state_q <= S_PROBE;
						end
					end
					S_DECIDE: begin
						prev_row_q <= cur_row_q;
						prev_col_q <= cur_col_q;
						if (found_q) begin
							cur_row_q <= nxt_row_q;
							cur_col_q <= nxt_col_q;
						end
						step_q  <= step_q + SW'(1);
						first_q <= 1'b0;
						state_q <= S_CHECK;
					end
					S_CHECK: begin
						dir_q   <= gptc_pkg::DIR_UP;
						ok_q    <= '0;
						found_q <= 1'b0;
						state_q <= S_PROBE;
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	// The first open neighbor in probe order that is not the cell we came from is the next cell.
	always_ff @(posedge clk) begin
		if (state_q == S_WAIT && rd_data && !nb_back && !found_q) begin
			nxt_row_q <= nb_row;
			nxt_col_q <= nb_col;
		end
		if (fin) begin
			path_good_q   <= fin_good;
			path_length_q <= LEN_W'(step_q);
		end
	end

	assign done        = done_q;
	assign path_good   = path_good_q;
	assign path_length = path_length_q;

`ifndef ASSERT_OFF
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == S_IDLE))
		else $error("verdict strobe while a trace is still running");

	a_trace_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_pixel) |=> busy)
		else $error("last pixel did not start a trace");

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("verdict strobe longer than one cycle");

	a_probe_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROBE) |-> (step_q < limit_q))
		else $error("walk probed past the step limit");
`endif

endmodule
